// ===== hw/rtl/mwd_pkg.sv =====
// ============================================================================
// mwd_pkg
// Shared word width, counter width and interface types of the multiword
// by single-word divider.
// ============================================================================
`default_nettype none

package mwd_pkg;

  // width of one dividend word and of the divisor as used by the datapath
  localparam int WORD_BITS  = 64;
  // width of the payload ports
  localparam int FIELD_BITS = 64;
  // bit counter holds up to two words of dividend bits
  localparam int CNT_W      = $clog2(2 * WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [2*WORD_BITS-1:0] dword_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // request from the control path to the serial divider
  typedef struct packed {
    logic  start;
    word_t hi;
    word_t lo;
  } mwd_cmd_t;

  // status from the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } mwd_sts_t;

  // top level control states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_ERR  = 3'b100
  } mwd_state_t;

endpackage : mwd_pkg

`default_nettype wire

// ===== hw/rtl/mwd_serial_div.sv =====
// ============================================================================
// mwd_serial_div
// Bit-serial restoring divider of a two-word value (hi:lo) by a one-word
// divisor. Gives the low word of the quotient and the exact remainder.
// ============================================================================
`default_nettype none

module mwd_serial_div import mwd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mwd_cmd_t cmd,
  input  wire word_t    divisor,
  output mwd_sts_t      sts,
  output word_t         quotient,
  output word_t         remainder
);

  logic   busy_r, busy_nxt;
  logic   done_r, done_nxt;
  cnt_t   cnt_r, cnt_nxt;
  dword_t sh_r, sh_nxt;
  word_t  rem_r, rem_nxt;
  word_t  quo_r, quo_nxt;

  // one restoring step
  logic                 top_bit;
  word_t                shifted;
  logic [WORD_BITS:0]   diff;
  logic                 take;

  assign top_bit = rem_r[WORD_BITS-1];
  assign shifted = {rem_r[WORD_BITS-2:0], sh_r[2*WORD_BITS-1]};
  assign diff    = {top_bit, shifted} - {1'b0, divisor};
  assign take    = top_bit || !diff[WORD_BITS];

  // next state of the divider
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      quo_nxt  = '0;
      if (cmd.hi < divisor) begin
        // high word already reduced: only the low word needs stepping
        rem_nxt = cmd.hi;
        sh_nxt  = {cmd.lo, {WORD_BITS{1'b0}}};
        cnt_nxt = CNT_W'(WORD_BITS);
      end else begin
        rem_nxt = '0;
        sh_nxt  = {cmd.hi, cmd.lo};
        cnt_nxt = CNT_W'(2 * WORD_BITS);
      end
    end else if (busy_r) begin
      sh_nxt  = {sh_r[2*WORD_BITS-2:0], 1'b0};
      rem_nxt = take ? diff[WORD_BITS-1:0] : shifted;
      quo_nxt = {quo_r[WORD_BITS-2:0], take};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule : mwd_serial_div

`default_nettype wire

// ===== hw/rtl/multiword_by_word_division_top.sv =====
// ============================================================================
// multiword_by_word_division_top
// Short division of a multiword unsigned dividend, streamed most significant
// word first, by a single-word divisor register.
// ============================================================================
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  in_dividend_word, in_final_word
//   out_     output     out_valid/out_ready out_quotient_word,
//                                          out_remainder_value,
//                                          out_end_of_number, out_zero_divisor
//   cfg_     input      cfg_wr_en          cfg_wr_data (divisor)
//
// Each accepted word is divided by the one-bit-per-cycle restoring divider, and
// its result is loaded into the output register once that register is free;
// when the carried remainder is not below the divisor both words are stepped.
// A zero divisor skips the divider and loads a zeroed result with the error flag.
// Reset sets the divisor to 1 and clears the carried remainder.
// A new word is taken while the previous result waits in the output register.
`default_nettype none

module multiword_by_word_division_top import mwd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FIELD_BITS-1:0] in_dividend_word,
  input  wire logic                  in_final_word,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [FIELD_BITS-1:0]      out_quotient_word,
  output logic [FIELD_BITS-1:0]      out_remainder_value,
  output logic                       out_end_of_number,
  output logic                       out_zero_divisor,
  input  wire logic                  cfg_wr_en,
  input  wire logic [FIELD_BITS-1:0] cfg_wr_data
);

  mwd_state_t state_r, state_nxt;
  word_t      divisor_r;
  word_t      part_rem_r, part_rem_nxt;
  logic       final_r;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_quo_r;
  word_t      out_rem_r;
  logic       out_eon_r;
  logic       out_err_r;

  mwd_cmd_t   cmd;
  mwd_sts_t   sts;
  word_t      div_quo;
  word_t      div_rem;

  logic       in_fire;
  logic       out_free;
  logic       res_ready;
  logic       res_load;
  logic       div_zero;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign div_zero  = (divisor_r == '0);
  assign res_ready = (state_r == ST_ERR) || ((state_r == ST_CALC) && sts.done);
  assign res_load  = res_ready && out_free;

  // start the divider on an accepted transaction with a usable divisor
  assign cmd.start = in_fire && !div_zero;
  assign cmd.hi    = part_rem_r;
  assign cmd.lo    = in_dividend_word[WORD_BITS-1:0];

  mwd_serial_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .divisor   (divisor_r),
    .sts       (sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // control state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = div_zero ? ST_ERR : ST_CALC;
      end
      ST_CALC: begin
        if (res_load) state_nxt = ST_IDLE;
      end
      ST_ERR: begin
        if (res_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // carried remainder and output valid
  always_comb begin
    part_rem_nxt  = part_rem_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      if (state_r == ST_CALC) part_rem_nxt = div_rem;
      if (final_r) part_rem_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      divisor_r   <= word_t'(1);
      part_rem_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      part_rem_r  <= part_rem_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) divisor_r <= cfg_wr_data[WORD_BITS-1:0];
    end
  end

  // transaction flag and output register
  always_ff @(posedge clk) begin
    if (in_fire) final_r <= in_final_word;
    if (res_load) begin
      out_eon_r <= final_r;
      out_err_r <= (state_r == ST_ERR);
      out_quo_r <= (state_r == ST_ERR) ? '0 : div_quo;
      out_rem_r <= (state_r == ST_ERR) ? '0 : div_rem;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_quotient_word   = FIELD_BITS'(out_quo_r);
  assign out_remainder_value = FIELD_BITS'(out_rem_r);
  assign out_end_of_number   = out_eon_r;
  assign out_zero_divisor    = out_err_r;

endmodule : multiword_by_word_division_top

`default_nettype wire
